/* rtl/urc_pkg.sv */
// Package for the ultrasonic range classifier: payload structs, register index
// codes, phase and zone encodings, and the constants of the distance divider.
// Depends on nothing; every other file of the block imports it.
package urc_pkg;

	localparam int WIDTH_BITS_DEF = 17;

	localparam int TIMEOUT_W = 16;
	localparam int TRIG_W    = 8;
	localparam int LIMIT_W   = 10;
	localparam int DIST_W    = 11;
	localparam int CFG_DATA_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd26100;
	localparam logic [TRIG_W-1:0]    TRIG_RST    = 8'd10;
	localparam logic [LIMIT_W-1:0]   STOP_RST    = 10'd6;
	localparam logic [LIMIT_W-1:0]   TURN_RST    = 10'd15;

	// Width / 58 is taken as (width >> 1) / 29, and that as a multiply by
	// ceil(2^21 / 29) followed by a shift. Exact for every 15-bit operand.
	localparam int             DIV_IN_W  = 16;
	localparam logic [16:0]    DIV_MAGIC = 17'd72316;
	localparam int             DIV_SHIFT = 21;
	localparam int             DIV_PROD_W = 32;

	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_TRIGGER = 2'd1,
		REG_STOP    = 2'd2,
		REG_TURN    = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_WAIT = 2'd2,
		PH_MEAS = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ZONE_STOP    = 2'd0,
		ZONE_TURN    = 2'd1,
		ZONE_ADVANCE = 2'd2
	} zone_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [TRIG_W-1:0]    trigger_ticks;
		logic [LIMIT_W-1:0]   stop_limit_cm;
		logic [LIMIT_W-1:0]   turn_limit_cm;
	} cfg_t;

	typedef struct packed {
		logic start_req;
		logic echo;
	} in_item_t;

	typedef struct packed {
		logic              trigger;
		logic              done_res;
		logic [DIST_W-1:0] distance_cm;
		logic              timed_out;
		zone_t             zone;
		logic              busy_res;
	} out_item_t;

endpackage

/* rtl/urc_cfg_regs.sv */
// Configuration register file of the range classifier: four registers written
// through a valid/ready channel that is always ready.
// Depends on urc_pkg.
module urc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  urc_pkg::cfg_index_t          cfg_index,
	input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_data,
	output urc_pkg::cfg_t                cfg
);
	import urc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.trigger_ticks <= TRIG_RST;
			cfg_q.stop_limit_cm <= STOP_RST;
			cfg_q.turn_limit_cm <= TURN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
				REG_TRIGGER: cfg_q.trigger_ticks <= cfg_data[TRIG_W-1:0];
				REG_STOP:    cfg_q.stop_limit_cm <= cfg_data[LIMIT_W-1:0];
				REG_TURN:    cfg_q.turn_limit_cm <= cfg_data[LIMIT_W-1:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

/* rtl/urc_core.sv */
// Measurement core of the range classifier: phase machine, trigger and echo
// counters, distance divider and zone classification, one tick per transfer.
// Depends on urc_pkg.
module urc_core #(
	parameter int WIDTH_BITS = urc_pkg::WIDTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  urc_pkg::in_item_t  tick,
	input  urc_pkg::cfg_t      cfg,
	output urc_pkg::out_item_t res
);
	import urc_pkg::*;

	localparam int CMP_W = ((WIDTH_BITS > TIMEOUT_W) ? WIDTH_BITS : TIMEOUT_W) + 1;

	phase_t                  phase_q, phase_n;
	logic [TRIG_W-1:0]       tcnt_q, tcnt_n;
	logic [WIDTH_BITS-1:0]   width_q, width_n;
	logic [DIST_W-1:0]       last_q, last_n;

	logic [TRIG_W-1:0]       trig_len;
	logic [TRIG_W-1:0]       tcnt_inc;
	logic                    trig_end;
	logic [WIDTH_BITS-1:0]   width_base;
	logic [WIDTH_BITS-1:0]   width_inc;
	logic                    width_at_max;
	logic                    over_timeout;
	logic [CMP_W-1:0]        width_q_ext;
	logic [DIV_PROD_W-1:0]   div_prod;
	logic [DIST_W-1:0]       quotient;
	logic                    done;
	logic                    tout;
	logic [DIST_W-1:0]       dist_cm;

	// Shared datapath terms.
	always_comb begin
		trig_len     = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
		tcnt_inc     = (tcnt_q != '1) ? tcnt_q + TRIG_W'(1) : tcnt_q;
		trig_end     = (tcnt_inc >= trig_len);
		width_base   = (phase_q == PH_WAIT) ? '0 : width_q;
		width_at_max = (width_base == '1);
		width_inc    = width_base + WIDTH_BITS'(1);
		over_timeout = (CMP_W'(width_inc) > CMP_W'(cfg.timeout_ticks));
		width_q_ext  = CMP_W'(width_q);
		div_prod     = DIV_PROD_W'(width_q_ext[DIV_IN_W-1:1]) * DIV_PROD_W'(DIV_MAGIC);
		quotient     = div_prod[DIV_SHIFT+DIST_W-1:DIV_SHIFT];
		done = 1'b0;
		tout = 1'b0;
		if (phase_q == PH_WAIT || phase_q == PH_MEAS) begin
			if (tick.echo) begin
				done = width_at_max || over_timeout;
				tout = done;
			end else begin
				done = (phase_q == PH_MEAS);
			end
		end
	end

	// Next phase.
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_IDLE: if (tick.start_req) begin
				phase_n = (trig_len == TRIG_W'(1)) ? PH_WAIT : PH_TRIG;
			end
			PH_TRIG: if (trig_end) begin
				phase_n = PH_WAIT;
			end
			PH_WAIT, PH_MEAS: begin
				if (done) begin
					phase_n = PH_IDLE;
				end else if (tick.echo) begin
					phase_n = PH_MEAS;
				end
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	// Counters and result fields.
	always_comb begin
		tcnt_n  = tcnt_q;
		width_n = width_q;
		last_n  = last_q;
		dist_cm = tout ? '0 : quotient;
		res.trigger  = 1'b0;
		res.done_res = done;
		res.timed_out = tout;
		res.zone     = ZONE_STOP;
		unique case (phase_q)
			PH_IDLE: if (tick.start_req) begin
				res.trigger = 1'b1;
				tcnt_n      = TRIG_W'(1);
				width_n     = '0;
			end
			PH_TRIG: begin
				res.trigger = 1'b1;
				tcnt_n      = tcnt_inc;
			end
			PH_WAIT, PH_MEAS: begin
				if (tick.echo) begin
					width_n = width_at_max ? width_base : width_inc;
				end
				if (done) begin
					width_n = '0;
					tcnt_n  = '0;
					last_n  = dist_cm;
					if (dist_cm <= DIST_W'(cfg.stop_limit_cm)) begin
						res.zone = ZONE_STOP;
					end else if (dist_cm <= DIST_W'(cfg.turn_limit_cm)) begin
						res.zone = ZONE_TURN;
					end else begin
						res.zone = ZONE_ADVANCE;
					end
				end
			end
			default: tcnt_n = tcnt_q;
		endcase
		res.distance_cm = last_n;
		res.busy_res    = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tcnt_q  <= '0;
			width_q <= '0;
			last_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			tcnt_q  <= tcnt_n;
			width_q <= width_n;
			last_q  <= last_n;
		end
	end

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_IDLE && tick.start_req) |=> (phase_q != PH_IDLE))
		else $error("start request in idle did not begin a measurement");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.done_res) |=> (phase_q == PH_IDLE && width_q == '0 && tcnt_q == '0))
		else $error("completed measurement did not return to idle");

	a_trig_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRIG) |-> (tcnt_q != '0 && res.trigger && !res.done_res))
		else $error("trigger phase with a zero count or a completion");

	a_width_in_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.done_res && !res.timed_out)
			|-> (CMP_W'(width_q) <= CMP_W'(cfg.timeout_ticks)))
		else $error("echo width above timeout reported as valid");

endmodule

/* rtl/urc_out_reg.sv */
// Result register of the range classifier: one registered slot between the
// core and result channel; upstream is ready if the slot is empty or drains.
// Depends on urc_pkg.
module urc_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  urc_pkg::out_item_t up_data,
	output logic               down_valid,
	input  logic               down_ready,
	output urc_pkg::out_item_t down_data
);
	import urc_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign up_ready   = !valid_q || down_ready;
	assign down_valid = valid_q;
	assign down_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= up_data;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !down_ready) |=> (valid_q && $stable(data_q)))
		else $error("stalled result was lost or changed");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready) |=> valid_q)
		else $error("accepted result did not appear");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && down_ready && !up_valid) |=> !valid_q)
		else $error("result delivered twice");

endmodule

/* rtl/ultrasonic_range_classifier.sv */
// Top level of the ultrasonic range classifier: configuration registers,
// measurement core and result register. Depends on urc_pkg, urc_cfg_regs,
// urc_core and urc_out_reg.
//
// Usage. Each transfer on the tick channel is one microsecond sample carrying
// a start request and the echo pin level. Every tick produces exactly one
// result transfer with the trigger level to drive, a done flag, the distance
// in centimeters, a timeout flag, the zone (stop, turn, advance) and busy.
// A start request while idle raises the trigger for trigger_ticks ticks, then
// the echo pulse is timed; on its falling edge the width divided by 58 gives
// the distance. An echo longer than timeout_ticks ends the measurement as
// timed out with distance zero.
//
// Timing: a tick's result is captured in the output register with its
// transfer, and a new tick is taken every cycle while the result slot is
// free or draining. The tick is handled in a single registered pass; the
// path is set by the divide-by-58 multiplier feeding the zone compares.
//
// Reset: the configuration returns to its defaults, the measurement returns
// to idle with cleared counters and a last distance of zero, and the result
// register is empty. Stall: while the receiver holds off a waiting result,
// tick_ready is low and the tick source waits. The configuration channel is
// always ready; writes are meant for idle periods.
module ultrasonic_range_classifier #(
	parameter int WIDTH_BITS = urc_pkg::WIDTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	output logic                           tick_ready,
	input  urc_pkg::in_item_t              tick,
	output logic                           result_valid,
	input  logic                           result_ready,
	output urc_pkg::out_item_t             result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  urc_pkg::cfg_index_t            cfg_index,
	input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import urc_pkg::*;

	cfg_t      cfg;
	out_item_t core_res;
	logic      tick_accept;

	// A tick is taken whenever the result slot is free or draining this cycle.
	assign tick_accept = tick_valid && tick_ready;

	urc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	urc_core #(
		.WIDTH_BITS (WIDTH_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (tick_accept),
		.tick   (tick),
		.cfg    (cfg),
		.res    (core_res)
	);

	urc_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (tick_valid),
		.up_ready   (tick_ready),
		.up_data    (core_res),
		.down_valid (result_valid),
		.down_ready (result_ready),
		.down_data  (result)
	);

endmodule
